[hw/rtl/h2r_pkg.sv]
// shared types and constants for the hsv to rgb converter
`timescale 1ns / 1ps

package h2r_pkg;

  // channel source picked by the hue sector
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_C    = 2'd1,
    SEL_X    = 2'd2
  } h2r_sel_t;

  // hue sectors of 60 degrees, the last one also takes everything above
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } h2r_sector_t;

  // per-stage advance strobes of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } h2r_adv_t;

  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;
  localparam int CHAN_W = 8;
  localparam int C_W    = 14;  // saturation * brightness, up to 16129
  localparam int W_W    = 6;   // 60 - |rem - 60|, up to 60
  localparam int REM_W  = 7;
  localparam int SUM_W  = 21;  // signed scaled channel sum
  localparam int N_W    = 24;  // sum * 17
  localparam int A_W    = N_W - 6;
  localparam int K_W    = 18;
  localparam int P_W    = A_W + K_W;

  // floor(sum * 255 / 600000) = floor((sum * 17 >> 6) / 625)
  localparam logic [N_W-1:0] SAT_LIMIT   = 24'd10240000;  // 256 * 40000
  localparam logic [K_W-1:0] RECIP_625   = 18'd214749;    // ceil(2^27 / 625)
  localparam int             RECIP_SHIFT = 27;

endpackage

[hw/rtl/h2r_front.sv]
// front stages: sector, chroma, secondary term and scaled channel sums
`timescale 1ns / 1ps

module h2r_front import h2r_pkg::*; (
  input  logic                    clk,
  input  h2r_adv_t                adv,
  input  logic [HUE_W-1:0]        hue,
  input  logic [PCT_W-1:0]        saturation,
  input  logic [PCT_W-1:0]        brightness,
  output logic signed [SUM_W-1:0] sum_c,
  output logic signed [SUM_W-1:0] sum_x,
  output logic signed [SUM_W-1:0] sum_0,
  output h2r_sel_t                sel_red,
  output h2r_sel_t                sel_green,
  output h2r_sel_t                sel_blue
);

  // stage 1 signals
  h2r_sector_t      sector_nxt, sector_r;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_off;
  logic [W_W-1:0]   w_nxt, w_r;
  logic [C_W-1:0]   c_nxt, c_r;
  logic [C_W-1:0]   bri100_nxt, bri100_r;

  // stage 2 signals
  logic [19:0]             cw;
  logic signed [C_W:0]     m;
  logic signed [SUM_W-1:0] m60;
  logic signed [SUM_W-1:0] sum_c_nxt, sum_c_r;
  logic signed [SUM_W-1:0] sum_x_nxt, sum_x_r;
  logic signed [SUM_W-1:0] sum_0_nxt, sum_0_r;
  h2r_sel_t sel_r_nxt, sel_r_r;
  h2r_sel_t sel_g_nxt, sel_g_r;
  h2r_sel_t sel_b_nxt, sel_b_r;

  always_comb begin
    priority if (hue < 9'd60)  sector_nxt = SEC_0;
    else if (hue < 9'd120)     sector_nxt = SEC_1;
    else if (hue < 9'd180)     sector_nxt = SEC_2;
    else if (hue < 9'd240)     sector_nxt = SEC_3;
    else if (hue < 9'd300)     sector_nxt = SEC_4;
    else                       sector_nxt = SEC_5;

    priority if (hue >= 9'd480) rem = REM_W'(hue - 9'd480);
    else if (hue >= 9'd360)     rem = REM_W'(hue - 9'd360);
    else if (hue >= 9'd240)     rem = REM_W'(hue - 9'd240);
    else if (hue >= 9'd120)     rem = REM_W'(hue - 9'd120);
    else                        rem = REM_W'(hue);

    rem_off    = (rem >= 7'd60) ? (rem - 7'd60) : (7'd60 - rem);
    w_nxt      = W_W'(7'd60 - rem_off);
    c_nxt      = C_W'(saturation) * C_W'(brightness);
    bri100_nxt = C_W'(brightness) * C_W'(100);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      sector_r <= sector_nxt;
      w_r      <= w_nxt;
      c_r      <= c_nxt;
      bri100_r <= bri100_nxt;
    end
  end

  always_comb begin
    cw        = 20'(c_r) * 20'(w_r);
    m         = $signed({1'b0, bri100_r}) - $signed({1'b0, c_r});
    m60       = SUM_W'(m) * 21'sd60;
    sum_x_nxt = $signed({1'b0, cw}) + m60;
    sum_0_nxt = m60;
    // c*60 + m*60 collapses to brightness * 6000
    sum_c_nxt = $signed({1'b0, 20'(bri100_r) * 20'd60});

    unique case (sector_r)
      SEC_0:   begin sel_r_nxt = SEL_C;    sel_g_nxt = SEL_X;    sel_b_nxt = SEL_ZERO; end
      SEC_1:   begin sel_r_nxt = SEL_X;    sel_g_nxt = SEL_C;    sel_b_nxt = SEL_ZERO; end
      SEC_2:   begin sel_r_nxt = SEL_ZERO; sel_g_nxt = SEL_C;    sel_b_nxt = SEL_X;    end
      SEC_3:   begin sel_r_nxt = SEL_ZERO; sel_g_nxt = SEL_X;    sel_b_nxt = SEL_C;    end
      SEC_4:   begin sel_r_nxt = SEL_X;    sel_g_nxt = SEL_ZERO; sel_b_nxt = SEL_C;    end
      default: begin sel_r_nxt = SEL_C;    sel_g_nxt = SEL_ZERO; sel_b_nxt = SEL_X;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      sum_c_r <= sum_c_nxt;
      sum_x_r <= sum_x_nxt;
      sum_0_r <= sum_0_nxt;
      sel_r_r <= sel_r_nxt;
      sel_g_r <= sel_g_nxt;
      sel_b_r <= sel_b_nxt;
    end
  end

  assign sum_c     = sum_c_r;
  assign sum_x     = sum_x_r;
  assign sum_0     = sum_0_r;
  assign sel_red   = sel_r_r;
  assign sel_green = sel_g_r;
  assign sel_blue  = sel_b_r;

endmodule

[hw/rtl/h2r_lane.sv]
// one output channel: source select, scale by 255/600000, clamp
`timescale 1ns / 1ps

module h2r_lane import h2r_pkg::*; (
  input  logic                    clk,
  input  h2r_adv_t                adv,
  input  h2r_sel_t                sel,
  input  logic signed [SUM_W-1:0] sum_c,
  input  logic signed [SUM_W-1:0] sum_x,
  input  logic signed [SUM_W-1:0] sum_0,
  output logic [CHAN_W-1:0]       chan
);

  logic signed [SUM_W-1:0] s;
  logic [N_W-1:0]          n;
  logic                    zero_nxt, zero_r;
  logic                    sat_nxt, sat_r;
  logic [A_W-1:0]          a_nxt, a_r;
  logic [P_W-1:0]          p;
  logic [CHAN_W-1:0]       chan_nxt, chan_r;

  always_comb begin
    unique case (sel)
      SEL_C:   s = sum_c;
      SEL_X:   s = sum_x;
      default: s = sum_0;
    endcase
    zero_nxt = s[SUM_W-1] || (s == '0);
    n        = N_W'(s[SUM_W-2:0]) * N_W'(17);
    sat_nxt  = (n >= SAT_LIMIT);
    a_nxt    = n[N_W-1:6];
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      zero_r <= zero_nxt;
      sat_r  <= sat_nxt;
      a_r    <= a_nxt;
    end
  end

  // exact divide by 625 through the reciprocal for a below 2^18
  always_comb begin
    p = P_W'(a_r) * P_W'(RECIP_625);
    priority if (zero_r) chan_nxt = '0;
    else if (sat_r)      chan_nxt = '1;
    else                 chan_nxt = p[RECIP_SHIFT +: CHAN_W];
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan = chan_r;

endmodule

[hw/rtl/hsv_to_rgb_converter.sv]
// top level of the hsv to rgb converter: four-stage pipeline and its control
//
//   channel  | ports                                        | direction
//   ---------+----------------------------------------------+----------
//   input    | in_valid, in_stall, in_hue, in_saturation,   | in
//            | in_brightness                                |
//   result   | out_valid, out_stall, out_red, out_green,    | out
//            | out_blue                                     |
//
// one word enters per clock while nothing stalls; each word passes through
// stages 1 to 4 in order. the depth is set by the two multiplies
// (chroma times secondary weight, and the reciprocal divide by 625) and
// the two selects. reset clears only the valid bits of the four stages.
// a stall on the result side holds only the stages that carry a word, so
// empty stages keep filling and in_stall rises once all four are occupied.
`timescale 1ns / 1ps

module hsv_to_rgb_converter import h2r_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [HUE_W-1:0]  in_hue,
  input  logic [PCT_W-1:0]  in_saturation,
  input  logic [PCT_W-1:0]  in_brightness,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue
);

  // stage valid bits, stage 4 is the output register
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic v4_r, v4_nxt;

  h2r_adv_t adv;

  logic signed [SUM_W-1:0] sum_c;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_0;
  h2r_sel_t sel_red;
  h2r_sel_t sel_green;
  h2r_sel_t sel_blue;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    adv.s4 = !v4_r || !out_stall;
    adv.s3 = !v3_r || adv.s4;
    adv.s2 = !v2_r || adv.s3;
    adv.s1 = !v1_r || adv.s2;

    v1_nxt = adv.s1 ? in_valid : v1_r;
    v2_nxt = adv.s2 ? v1_r     : v2_r;
    v3_nxt = adv.s3 ? v2_r     : v3_r;
    v4_nxt = adv.s4 ? v3_r     : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign in_stall  = !adv.s1;
  assign out_valid = v4_r;

  // stages 1 and 2: sector, chroma and the three candidate sums
  h2r_front u_front (
    .clk        (clk),
    .adv        (adv),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .sum_c      (sum_c),
    .sum_x      (sum_x),
    .sum_0      (sum_0),
    .sel_red    (sel_red),
    .sel_green  (sel_green),
    .sel_blue   (sel_blue)
  );

  // stages 3 and 4: one lane per color channel
  h2r_lane u_lane_red (
    .clk   (clk),
    .adv   (adv),
    .sel   (sel_red),
    .sum_c (sum_c),
    .sum_x (sum_x),
    .sum_0 (sum_0),
    .chan  (out_red)
  );

  h2r_lane u_lane_green (
    .clk   (clk),
    .adv   (adv),
    .sel   (sel_green),
    .sum_c (sum_c),
    .sum_x (sum_x),
    .sum_0 (sum_0),
    .chan  (out_green)
  );

  h2r_lane u_lane_blue (
    .clk   (clk),
    .adv   (adv),
    .sel   (sel_blue),
    .sum_c (sum_c),
    .sum_x (sum_x),
    .sum_0 (sum_0),
    .chan  (out_blue)
  );

`ifndef SYNTH
  // an accepted word lands in stage 1
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted word missing from stage 1");

  // a held word in stage 2 is not dropped
  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !adv.s3) |=> v2_r)
    else $error("stalled word lost in stage 2");

  // a delivered result with nothing behind it leaves the output empty
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !v3_r) |=> !out_valid)
    else $error("result repeated after delivery");

  // the input side only stalls when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_stall))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

[dv/testbench.sv]
// self-checking testbench for the hsv to rgb converter with a color scoreboard
`timescale 1ns / 1ps

module testbench;
  import h2r_pkg::*;

  // one rgb word as it leaves the block
  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // keeps predicted colors in order and compares each result against the oldest one
  class color_scoreboard;
    rgb_t pending_colors[$];
    int   failures;

    // floor(sum * 255 / 600000), clamped to the 8-bit range
    function logic [CHAN_W-1:0] scale_channel(longint sum);
      longint level;
      if (sum <= 0) return '0;
      level = (sum * 255) / 600000;
      if (level > 255) level = 255;
      return level[CHAN_W-1:0];
    endfunction

    // exact integer hsv to rgb: every term is kept scaled by 60
    function rgb_t to_rgb(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                          logic [PCT_W-1:0] bri);
      longint      chroma;
      longint      rem_off;
      longint      c60;
      longint      x60;
      longint      m60;
      longint      src;
      h2r_sector_t sector;
      h2r_sel_t    sel [3];
      logic [CHAN_W-1:0] chan [3];
      rgb_t        res;
      chroma  = longint'(sat) * longint'(bri);
      rem_off = (longint'(hue) % 120) - 60;
      if (rem_off < 0) rem_off = -rem_off;
      c60 = chroma * 60;
      x60 = chroma * (60 - rem_off);
      m60 = (longint'(bri) * 100 - chroma) * 60;
      if (hue < 60)       sector = SEC_0;
      else if (hue < 120) sector = SEC_1;
      else if (hue < 180) sector = SEC_2;
      else if (hue < 240) sector = SEC_3;
      else if (hue < 300) sector = SEC_4;
      else                sector = SEC_5;
      case (sector)
        SEC_0: sel = '{SEL_C, SEL_X, SEL_ZERO};
        SEC_1: sel = '{SEL_X, SEL_C, SEL_ZERO};
        SEC_2: sel = '{SEL_ZERO, SEL_C, SEL_X};
        SEC_3: sel = '{SEL_ZERO, SEL_X, SEL_C};
        SEC_4: sel = '{SEL_X, SEL_ZERO, SEL_C};
        default: sel = '{SEL_C, SEL_ZERO, SEL_X};
      endcase
      for (int i = 0; i < 3; i++) begin
        case (sel[i])
          SEL_C:   src = c60;
          SEL_X:   src = x60;
          default: src = 0;
        endcase
        chan[i] = scale_channel(src + m60);
      end
      res.red   = chan[0];
      res.green = chan[1];
      res.blue  = chan[2];
      return res;
    endfunction

    function void note_color(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                             logic [PCT_W-1:0] bri);
      pending_colors.push_back(to_rgb(hue, sat, bri));
    endfunction

    function void check_color(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                              logic [CHAN_W-1:0] blue);
      rgb_t want;
      if (pending_colors.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] unexpected rgb word %0d %0d %0d", $realtime, red, green, blue);
        return;
      end
      want = pending_colors.pop_front();
      if (red !== want.red || green !== want.green || blue !== want.blue) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] rgb mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                   $realtime, want.red, want.green, want.blue, red, green, blue);
      end
    endfunction

    function int pending();
      return pending_colors.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [HUE_W-1:0]  in_hue;
  logic [PCT_W-1:0]  in_saturation;
  logic [PCT_W-1:0]  in_brightness;
  logic              out_valid;
  logic              out_stall;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;

  color_scoreboard scb = new();

  // calm: a stretch of the run with no idling on either side
  // quiet: the tail of the run, never any idling
  bit calm;
  bit quiet;

  hsv_to_rgb_converter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // present one color at the falling edge and hold it until the block takes it;
  // valid stays high afterwards so back-to-back words need no gap
  task automatic send_color(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                            input logic [PCT_W-1:0] bri);
    in_valid      = 1'b1;
    in_hue        = hue;
    in_saturation = sat;
    in_brightness = bri;
    do @(posedge clk); while (in_stall);
    scb.note_color(hue, sat, bri);
    @(negedge clk);
  endtask

  // sender gap: drop valid for a burst and scramble the idle payload
  task automatic idle_input(input int cycles);
    in_valid = 1'b0;
    repeat (cycles) begin
      in_hue        = HUE_W'($urandom);
      in_saturation = PCT_W'($urandom);
      in_brightness = PCT_W'($urandom);
      @(negedge clk);
    end
  endtask

  // random color: mostly the nominal ranges, sometimes sector edges,
  // sometimes anything the field widths allow
  task automatic send_random_color();
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] bri;
    int               pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      hue = HUE_W'($urandom_range(0, 360));
      sat = PCT_W'($urandom_range(0, 100));
      bri = PCT_W'($urandom_range(0, 100));
    end else if (pick < 8) begin
      // right at or next to a 60 degree boundary
      hue = HUE_W'($urandom_range(0, 6) * 60 + $urandom_range(0, 2) - 1);
      sat = PCT_W'($urandom_range(0, 100));
      bri = PCT_W'($urandom_range(0, 100));
    end else begin
      hue = HUE_W'($urandom);
      sat = PCT_W'($urandom);
      bri = PCT_W'($urandom);
    end
    send_color(hue, sat, bri);
  endtask

  // result side: random stall bursts raised and dropped at the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !calm && !quiet && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      scb.check_color(out_red, out_green, out_blue);
  end

  // main sequence
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_brightness = '0;
    calm          = 1'b0;
    quiet         = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every sector on both sides of its edges
    send_color(9'd0,   7'd100, 7'd100);
    send_color(9'd59,  7'd100, 7'd100);
    send_color(9'd60,  7'd100, 7'd100);
    send_color(9'd119, 7'd80,  7'd90);
    send_color(9'd120, 7'd80,  7'd90);
    send_color(9'd179, 7'd55,  7'd70);
    send_color(9'd180, 7'd55,  7'd70);
    send_color(9'd239, 7'd100, 7'd50);
    send_color(9'd240, 7'd100, 7'd50);
    send_color(9'd299, 7'd33,  7'd66);
    send_color(9'd300, 7'd33,  7'd66);
    send_color(9'd359, 7'd100, 7'd100);
    // full circle wraps to the same color as hue zero
    send_color(9'd360, 7'd100, 7'd100);
    // past the circle: falls in the last sector, rem keeps cycling
    send_color(9'd361, 7'd100, 7'd100);
    send_color(9'd480, 7'd70,  7'd80);
    send_color(9'd511, 7'd127, 7'd127);
    // grey and black
    send_color(9'd200, 7'd0,   7'd100);
    send_color(9'd200, 7'd100, 7'd0);
    send_color(9'd0,   7'd0,   7'd0);
    // oversaturated: negative offset clamps to zero
    send_color(9'd30,  7'd127, 7'd40);
    send_color(9'd150, 7'd127, 7'd100);
    // overbright: channels clip at full scale
    send_color(9'd90,  7'd20,  7'd127);
    send_color(9'd270, 7'd0,   7'd127);

    // random traffic in blocks, each block busy or calm; tail has no idling
    for (int n = 0; n < 1500; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 1300) quiet = 1'b1;
      if (!calm && !quiet && $urandom_range(0, 7) == 0)
        idle_input($urandom_range(1, 15));
      send_random_color();
    end
    in_valid = 1'b0;

    // drain, then let the pipeline settle to catch stray words
    while (scb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (scb.failures == 0 && scb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
